// ----- hdl/svp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg
// Shared constants, CORDIC angle table and unit latencies for the
// space vector PWM duty core.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int VOLT_W       = 16;
    localparam int ANG_IN_W     = 16;
    localparam int VLIM_W       = 15;
    localparam int SEC_W        = 3;
    localparam int TURN_W       = 32;
    localparam int CORDIC_STEPS = 24;

    localparam logic [VLIM_W-1:0] VLIM_RESET = 15'd3072;
    localparam logic [31:0] SQRT3_GAIN_Q30   = 32'd1129354066;
    localparam logic [31:0] HALF_TURN        = 32'h8000_0000;

    // Reciprocal of three for exact floor division of 32-bit values
    localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
    localparam int          RECIP3_SH = 33;

    // Pipeline depths of the arithmetic units
    localparam int MAG_LAT  = 50;
    localparam int ATAN_LAT = CORDIC_STEPS + 1;
    localparam int SIN_LAT  = CORDIC_STEPS;

    // Sector codes
    localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;
    localparam logic [SEC_W-1:0] SECTOR_5 = 3'd5;
    localparam logic [SEC_W-1:0] SECTOR_6 = 3'd6;

    // atan(2^-i) in 32-bit fractions of a turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        begin
            case (i)
                0:  a = 32'd536870912;
                1:  a = 32'd316933406;
                2:  a = 32'd167458907;
                3:  a = 32'd85004756;
                4:  a = 32'd42667331;
                5:  a = 32'd21354465;
                6:  a = 32'd10679838;
                7:  a = 32'd5340245;
                8:  a = 32'd2670163;
                9:  a = 32'd1335087;
                10: a = 32'd667544;
                11: a = 32'd333772;
                12: a = 32'd166886;
                13: a = 32'd83443;
                14: a = 32'd41722;
                15: a = 32'd20861;
                16: a = 32'd10430;
                17: a = 32'd5215;
                18: a = 32'd2608;
                19: a = 32'd1304;
                20: a = 32'd652;
                21: a = 32'd326;
                22: a = 32'd163;
                23: a = 32'd81;
                default: a = 32'd0;
            endcase
            return a;
        end
    endfunction

endpackage

// ----- hdl/svp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_in_if
// Command channel: dq voltages and electrical angle, valid/ready.
// ----------------------------------------------------------------------------
interface svp_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  quad_voltage;
    logic signed [15:0]  direct_voltage;
    logic [15:0]         elec_angle;

    modport source (output valid, output quad_voltage, output direct_voltage,
                    output elec_angle, input ready);
    modport sink   (input valid, input quad_voltage, input direct_voltage,
                    input elec_angle, output ready);
endinterface

// ----- hdl/svp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_out_if
// Result channel: three phase duties and the sector, valid/ready.
// ----------------------------------------------------------------------------
interface svp_out_if #(parameter int DUTY_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty_a;
    logic [DUTY_BITS-1:0] duty_b;
    logic [DUTY_BITS-1:0] duty_c;
    logic [2:0]           sector_num;

    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output sector_num, input ready);
    modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                    input sector_num, output ready);
endinterface

// ----- hdl/space_vector_pwm_duty_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core
// Centred space vector PWM duties from dq voltage commands and an angle.
// ----------------------------------------------------------------------------
// Fully pipelined: one command item is taken every clock cycle while no
// finished item waits at the output. The angle path runs through the
// input register, 25-stage atan2 CORDIC, angle and divide-by-six stages,
// 24-stage sine CORDIC, T1/T2 multiply and duty output register; the
// magnitude path (square root and 32-bit divide, 50 stages) runs alongside.
// The whole pipeline holds while a finished item waits at the output.
// The supply limit register must only be written while no item is in flight.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core
    import svp_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int DUTY_BITS  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [VLIM_W-1:0] cfg_wr_data,
    svp_in_if.sink            cmd,
    svp_out_if.source         pwm
);

    localparam int LAT      = 1 + ATAN_LAT + 2 + SIN_LAT + 2;
    localparam int SEC_DLY  = SIN_LAT + 2;
    localparam int TW       = 64 - (46 - DUTY_BITS);
    localparam int SW       = TW + 3;
    localparam int AB       = ANGLE_BITS;

    logic                     en;
    logic                     vld_reg [0:LAT-1];
    logic [VLIM_W-1:0]        vlim_reg;
    logic signed [VOLT_W-1:0] uq_reg, ud_reg;
    logic [ANG_IN_W-1:0]      ang_reg;
    logic [ANG_IN_W-1:0]      ang_dly_reg [0:ATAN_LAT-1];
    logic [TURN_W-1:0]        atan_ang;
    logic [31:0]              m_raw, m_dly_reg;
    logic [SEC_W-1:0]         sec_reg;
    logic [SEC_W-1:0]         sec_dly_reg [0:SEC_DLY-1];
    logic [31:0]              half1_reg, half2_reg;
    logic [31:0]              z1_reg, z2_reg;
    logic [31:0]              s1, s2;
    logic [63:0]              prod1_reg, prod2_reg;
    logic [DUTY_BITS-1:0]     duty_a_reg, duty_b_reg, duty_c_reg;
    logic [SEC_W-1:0]         sec_out_reg;

    // Angle stage signals
    logic [31:0]              th32;
    logic [AB-1:0]            theta;
    logic [AB+2:0]            t6;
    logic [AB-1:0]            phi;
    logic [AB:0]              comp;
    logic [32:0]              wide1, wide2;
    logic [63:0]              rq1, rq2;

    // Duty stage signals
    logic signed [SW-1:0]     t1, t2, one;
    logic [DUTY_BITS-1:0]     hi, lo, p1, p2;
    logic [DUTY_BITS-1:0]     da_next, db_next, dc_next;

    // Advance when the output stage is empty or being taken
    assign en        = !vld_reg[LAT-1] || pwm.ready;
    assign cmd.ready = en;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vlim_reg <= VLIM_RESET;
        else if (cfg_wr_en)
            vlim_reg <= cfg_wr_data;
    end

    // Valid line travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LAT; j++)
                vld_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= cmd.valid;
            for (int j = 1; j < LAT; j++)
                vld_reg[j] <= vld_reg[j-1];
        end
    end

    // Capture the command
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uq_reg  <= cmd.quad_voltage;
            ud_reg  <= cmd.direct_voltage;
            ang_reg <= cmd.elec_angle;
        end
    end

    svp_mag u_mag (
        .clk       (clk),
        .en        (en),
        .uq        (uq_reg),
        .ud        (ud_reg),
        .vlim      (vlim_reg),
        .mod_ratio (m_raw)
    );

    svp_atan u_atan (
        .clk   (clk),
        .en    (en),
        .uq    (uq_reg),
        .ud    (ud_reg),
        .angle (atan_ang)
    );

    // Hold the angle alongside the atan2 pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_dly_reg[0] <= ang_reg;
            for (int j = 1; j < ATAN_LAT; j++)
                ang_dly_reg[j] <= ang_dly_reg[j-1];
        end
    end

    // Combine angles, split into sector and in-sector angle
    always_comb
    begin
        th32  = {ang_dly_reg[ATAN_LAT-1], 16'd0} + atan_ang;
        theta = th32[31 -: AB];
        t6    = {1'b0, theta, 2'b00} + {2'b00, theta, 1'b0};
        phi   = t6[AB-1:0];
        comp  = (AB+1)'(1) << AB;
        comp  = comp - {1'b0, phi};
        wide2 = {1'b0, phi, {(32-AB){1'b0}}};
        wide1 = {comp, {(32-AB){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec_reg   <= t6[AB+2:AB] + SEC_W'(1);
            half1_reg <= wide1[32:1];
            half2_reg <= wide2[32:1];
        end
    end

    // Divide by six: halve, then multiply by the reciprocal of three
    assign rq1 = half1_reg * RECIP3;
    assign rq2 = half2_reg * RECIP3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg <= 32'(rq1 >> RECIP3_SH);
            z2_reg <= 32'(rq2 >> RECIP3_SH);
        end
    end

    svp_sin u_sin1 (
        .clk     (clk),
        .en      (en),
        .z_in    (z1_reg),
        .sin_out (s1)
    );

    svp_sin u_sin2 (
        .clk     (clk),
        .en      (en),
        .z_in    (z2_reg),
        .sin_out (s2)
    );

    // Align sector with the sine lanes and the ratio with the sines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec_dly_reg[0] <= sec_reg;
            for (int j = 1; j < SEC_DLY; j++)
                sec_dly_reg[j] <= sec_dly_reg[j-1];
            m_dly_reg <= m_raw;
        end
    end

    // Scale the sines by the modulation ratio
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= 64'(s1) * 64'(m_dly_reg);
            prod2_reg <= 64'(s2) * 64'(m_dly_reg);
        end
    end

    // Halve and saturate to [0, full scale)
    function automatic logic [DUTY_BITS-1:0] sat_duty(input logic signed [SW-1:0] twice);
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] top;
        begin
            d   = twice >>> 1;
            top = (SW'(1) <<< DUTY_BITS) - SW'(1);
            if (d < 0)
                return '0;
            else if (d > top)
                return {DUTY_BITS{1'b1}};
            else
                return d[DUTY_BITS-1:0];
        end
    endfunction

    always_comb
    begin
        t1  = $signed({3'b000, prod1_reg[63 -: TW]});
        t2  = $signed({3'b000, prod2_reg[63 -: TW]});
        one = SW'(1) <<< DUTY_BITS;
        hi  = sat_duty(one + t1 + t2);
        lo  = sat_duty(one - t1 - t2);
        p1  = sat_duty(one + t1 - t2);
        p2  = sat_duty(one - t1 + t2);
        case (sec_dly_reg[SEC_DLY-1])
            SECTOR_1: begin da_next = hi; db_next = p2; dc_next = lo; end
            SECTOR_2: begin da_next = p1; db_next = hi; dc_next = lo; end
            SECTOR_3: begin da_next = lo; db_next = hi; dc_next = p2; end
            SECTOR_4: begin da_next = lo; db_next = p1; dc_next = hi; end
            SECTOR_5: begin da_next = p2; db_next = lo; dc_next = hi; end
            SECTOR_6: begin da_next = hi; db_next = lo; dc_next = p1; end
            default:  begin da_next = '0; db_next = '0; dc_next = '0; end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            duty_a_reg  <= da_next;
            duty_b_reg  <= db_next;
            duty_c_reg  <= dc_next;
            sec_out_reg <= sec_dly_reg[SEC_DLY-1];
        end
    end

    assign pwm.valid      = vld_reg[LAT-1];
    assign pwm.duty_a     = duty_a_reg;
    assign pwm.duty_b     = duty_b_reg;
    assign pwm.duty_c     = duty_c_reg;
    assign pwm.sector_num = sec_out_reg;

    // A waiting result blocks new commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (pwm.valid && !pwm.ready) |-> !cmd.ready)
        else $error("command taken while result stalled");

    // Every delivered sector lies in one through six
    assert property (@(posedge clk) disable iff (!rst_n)
        pwm.valid |-> (pwm.sector_num >= SECTOR_1 && pwm.sector_num <= SECTOR_6))
        else $error("sector out of range");

    // A stalled pipeline keeps its results
    assert property (@(posedge clk) disable iff (!rst_n)
        (pwm.valid && !pwm.ready) |=> $stable(duty_a_reg) && $stable(sec_out_reg))
        else $error("result changed under stall");

endmodule

// ----- hdl/svp_mag.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_mag
// Modulation ratio: squares, 16-stage bitwise square root and 32-stage
// restoring divide by the voltage limit. Unsigned Q16.16 result.
// ----------------------------------------------------------------------------
module svp_mag
    import svp_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [VOLT_W-1:0] uq,
    input  logic signed [VOLT_W-1:0] ud,
    input  logic [VLIM_W-1:0]        vlim,
    output logic [31:0]              mod_ratio
);

    logic signed [31:0] sq_q_reg, sq_d_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        rad_reg  [0:15];
    logic [31:0]        root_reg [0:15];
    logic [31:0]        wrd_reg  [0:31];
    logic [VLIM_W-1:0]  rem_reg  [0:31];
    logic [VLIM_W-1:0]  vlim_eff;

    // Treat a zero limit as one
    assign vlim_eff = (vlim == '0) ? VLIM_W'(1) : vlim;

    // Square and sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_q_reg <= uq * uq;
            sq_d_reg <= ud * ud;
            sum_reg  <= 32'(sq_q_reg) + 32'(sq_d_reg);
        end
    end

    // Square root, one result bit per stage
    genvar k;
    generate
        for (k = 0; k < 16; k++)
        begin : g_root
            localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
            logic [31:0] v_in, r_in, v_next, r_next;
            logic [32:0] trial;
            if (k == 0)
            begin : g_first
                assign v_in = sum_reg;
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign v_in = rad_reg[k-1];
                assign r_in = root_reg[k-1];
            end
            always_comb
            begin
                trial = {1'b0, r_in} + {1'b0, BIT};
                if ({1'b0, v_in} >= trial)
                begin
                    v_next = v_in - trial[31:0];
                    r_next = (r_in >> 1) + BIT;
                end
                else
                begin
                    v_next = v_in;
                    r_next = r_in >> 1;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= v_next;
                    root_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    // Restoring divide of root * 2^16, one quotient bit per stage
    generate
        for (k = 0; k < 32; k++)
        begin : g_div
            logic [31:0]       w_in, w_next;
            logic [VLIM_W-1:0] r_in, r_next;
            logic [VLIM_W:0]   part;
            logic              qbit;
            if (k == 0)
            begin : g_first
                assign w_in = {root_reg[15][15:0], 16'd0};
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign w_in = wrd_reg[k-1];
                assign r_in = rem_reg[k-1];
            end
            always_comb
            begin
                part = {r_in, w_in[31]};
                qbit = (part >= {1'b0, vlim_eff});
                if (qbit)
                    r_next = VLIM_W'(part - {1'b0, vlim_eff});
                else
                    r_next = part[VLIM_W-1:0];
                w_next = {w_in[30:0], qbit};
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    wrd_reg[k] <= w_next;
                    rem_reg[k] <= r_next;
                end
            end
        end
    endgenerate

    assign mod_ratio = wrd_reg[31];

endmodule

// ----- hdl/svp_atan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_atan
// Vectoring CORDIC: atan2(uq, ud) in 32-bit turn units, one rotation per
// stage after a half-plane fold stage.
// ----------------------------------------------------------------------------
module svp_atan
    import svp_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [VOLT_W-1:0] uq,
    input  logic signed [VOLT_W-1:0] ud,
    output logic [TURN_W-1:0]        angle
);

    logic signed [26:0] x_reg [0:CORDIC_STEPS];
    logic signed [26:0] y_reg [0:CORDIC_STEPS];
    logic [31:0]        z_reg [0:CORDIC_STEPS];
    logic               zf_reg [0:CORDIC_STEPS];
    logic signed [26:0] xs, ys;

    // Scale by 256, fold the left half plane onto the right
    assign xs = {{3{ud[15]}}, ud, 8'd0};
    assign ys = {{3{uq[15]}}, uq, 8'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zf_reg[0] <= (ud == '0) && (uq == '0);
            if (xs < 0)
            begin
                x_reg[0] <= -xs;
                y_reg[0] <= -ys;
                z_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
        end
    end

    // Drive y toward zero, accumulate the angle
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            localparam logic [31:0] ANG = atan_turn(i);
            logic signed [26:0] dx, dy;
            assign dx = y_reg[i] >>> i;
            assign dy = x_reg[i] >>> i;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zf_reg[i+1] <= zf_reg[i];
                    if (!y_reg[i][26])
                    begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + ANG;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - ANG;
                    end
                end
            end
        end
    endgenerate

    // Zero vector has no angle
    assign angle = zf_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];

endmodule

// ----- hdl/svp_sin.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_sin
// Rotation CORDIC lane: sqrt3*sin(z) in Q2.30 for z in [0, 60 deg] given
// in turn units, one rotation per stage, clamped non-negative.
// ----------------------------------------------------------------------------
module svp_sin
    import svp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] z_in,
    output logic [31:0] sin_out
);

    logic signed [33:0] x_reg [0:CORDIC_STEPS-1];
    logic signed [33:0] y_reg [0:CORDIC_STEPS-1];
    logic signed [32:0] z_reg [0:CORDIC_STEPS-1];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            localparam logic signed [32:0] ANG = {1'b0, atan_turn(i)};
            logic signed [33:0] x_in, y_in, dx, dy;
            logic signed [32:0] zi;
            if (i == 0)
            begin : g_first
                assign x_in = {2'b00, SQRT3_GAIN_Q30};
                assign y_in = '0;
                assign zi   = {1'b0, z_in};
            end
            else
            begin : g_rest
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign zi   = z_reg[i-1];
            end
            assign dx = y_in >>> i;
            assign dy = x_in >>> i;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!zi[32])
                    begin
                        x_reg[i] <= x_in - dx;
                        y_reg[i] <= y_in + dy;
                        z_reg[i] <= zi - ANG;
                    end
                    else
                    begin
                        x_reg[i] <= x_in + dx;
                        y_reg[i] <= y_in - dy;
                        z_reg[i] <= zi + ANG;
                    end
                end
            end
        end
    endgenerate

    // Clamp to non-negative
    assign sin_out = y_reg[CORDIC_STEPS-1][33] ? '0 : y_reg[CORDIC_STEPS-1][31:0];

endmodule
